### hdl/b64sc_pkg.sv
`timescale 1ns / 1ps

package b64sc_pkg;

    // ascii codes used by the codec
    localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
    localparam logic [7:0] CHAR_UP_A  = 8'h41;   // 'A'
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;   // 'Z'
    localparam logic [7:0] CHAR_LO_A  = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;   // 'z'
    localparam logic [7:0] CHAR_0     = 8'h30;   // '0'
    localparam logic [7:0] CHAR_9     = 8'h39;   // '9'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;   // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;   // '/'

    // codec_mode values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // decoded symbol: value and whether it is in the alphabet
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sym;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + CHAR_UP_A;
        end else if (v < 6'd52) begin
            return w + (CHAR_LO_A - 8'd26);
        end else if (v < 6'd62) begin
            return w + (CHAR_0 - 8'd52);
        end else if (v == 6'd62) begin
            return CHAR_PLUS;
        end
        return CHAR_SLASH;
    endfunction

    // alphabet character to 6-bit value
    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym       s;
        logic [7:0] d;
        s = '0;
        d = 8'h00;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = c - CHAR_UP_A;
            s.valid = 1'b1;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = c - CHAR_LO_A + 8'd26;
            s.valid = 1'b1;
        end else if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0 + 8'd52;
            s.valid = 1'b1;
        end else if (c == CHAR_PLUS) begin
            d = 8'd62;
            s.valid = 1'b1;
        end else if (c == CHAR_SLASH) begin
            d = 8'd63;
            s.valid = 1'b1;
        end
        s.value = d[5:0];
        return s;
    endfunction

endpackage

### hdl/base64_stream_codec_top.sv
`timescale 1ns / 1ps

// channel   | direction | signals                                  | word
// ----------+-----------+------------------------------------------+---------------------------
// s_axis    | in        | tvalid tready tdata[7:0] tlast           | tdata: in_byte; tlast: in_last
// m_axis    | out       | tvalid tready tdata[7:0] tlast tuser[0]  | tdata: out_byte; tlast: run_end;
//           |           |                                          | tuser: bad_symbol
// cfg       | in        | i_cfg_wr_en i_cfg_wr_data                | codec_mode
//
// a word that completes a group loads the 1..4 results into the output register in
// the accept cycle; they leave one per cycle on m_axis while m_axis_tready is high,
// the first on the next cycle. s_axis_tready is high while the output register is
// empty or hands out its last word, so no input is taken while more words wait.
// reset (synchronous, active low) clears the mode and the group state and empties the output register.
// a stall on m_axis holds the output register, and s_axis until its last word is taken.

module base64_stream_codec_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] bad_symbol
);

    // group state
    logic        r_mode;
    logic [23:0] r_bits;
    logic [1:0]  r_cnt;
    logic [1:0]  r_pad;
    logic        r_err;

    // output register: up to four words, lowest byte leaves first
    logic [31:0] r_obuf;
    logic [2:0]  r_ocnt;
    logic        r_oerr;

    logic [23:0] n_bits;
    logic [1:0]  n_cnt;
    logic [1:0]  n_pad;
    logic        n_err;
    logic        n_done;
    logic [31:0] n_obuf;
    logic [2:0]  n_ocnt;

    logic        in_acc;
    logic        out_acc;
    logic [2:0]  grp_n;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [1:0]  dec_pad;
    logic        dec_err;
    logic        is_pad;
    logic [5:0]  dec_val;
    logic [1:0]  fin_pad;
    b64sc_pkg::t_sym sym;

    // handshakes
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_ocnt == 3'd0) || (r_ocnt == 3'd1 && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = (r_ocnt != 3'd0);
    assign m_axis_tdata    = r_obuf[7:0];
    assign m_axis_tlast    = (r_ocnt == 3'd1);
    assign m_axis_tuser[0] = r_oerr;

    assign grp_n = {1'b0, r_cnt} + 3'd1;

    // encode: merge the byte into the group
    always_comb begin
        unique case (r_cnt)
            2'd0:    enc_bits = r_bits | {s_axis_tdata, 16'h0000};
            2'd1:    enc_bits = r_bits | {8'h00, s_axis_tdata, 8'h00};
            default: enc_bits = r_bits | {16'h0000, s_axis_tdata};
        endcase
    end

    // decode: symbol value, padding marks and error
    always_comb begin
        sym     = b64sc_pkg::sym_decode(s_axis_tdata);
        is_pad  = (s_axis_tdata == b64sc_pkg::PAD_CHAR);
        dec_val = (sym.valid && !is_pad) ? sym.value : 6'd0;
        dec_err = r_err | (!is_pad && !sym.valid);
        dec_pad = r_pad;
        if (is_pad && r_cnt == 2'd2) begin
            dec_pad[1] = 1'b1;
        end
        if (is_pad && r_cnt == 2'd3) begin
            dec_pad[0] = 1'b1;
        end
        unique case (r_cnt)
            2'd0: dec_bits = r_bits | {dec_val, 18'h0};
            2'd1: dec_bits = r_bits | {6'h0, dec_val, 12'h0};
            2'd2: dec_bits = r_bits | {12'h0, dec_val, 6'h0};
            2'd3: dec_bits = r_bits | {18'h0, dec_val};
        endcase
        // missing positions of a short group count as padding
        fin_pad = dec_pad;
        if (grp_n < 3'd3) begin
            fin_pad[1] = 1'b1;
        end
        if (grp_n < 3'd4) begin
            fin_pad[0] = 1'b1;
        end
    end

    // next group state and output words
    always_comb begin
        if (r_mode == b64sc_pkg::MODE_ENCODE) begin
            n_done = (grp_n == 3'd3) || s_axis_tlast;
            n_bits = enc_bits;
            n_pad  = r_pad;
            n_err  = r_err;
            n_obuf[7:0]   = b64sc_pkg::sym_char(enc_bits[23:18]);
            n_obuf[15:8]  = b64sc_pkg::sym_char(enc_bits[17:12]);
            n_obuf[23:16] = (grp_n >= 3'd2) ? b64sc_pkg::sym_char(enc_bits[11:6])
                                            : b64sc_pkg::PAD_CHAR;
            n_obuf[31:24] = (grp_n >= 3'd3) ? b64sc_pkg::sym_char(enc_bits[5:0])
                                            : b64sc_pkg::PAD_CHAR;
            n_ocnt = 3'd4;
        end else begin
            n_done = (r_cnt == 2'd3) || s_axis_tlast;
            n_bits = dec_bits;
            n_pad  = dec_pad;
            n_err  = dec_err;
            n_obuf[7:0]   = dec_bits[23:16];
            n_obuf[15:8]  = fin_pad[1] ? dec_bits[7:0] : dec_bits[15:8];
            n_obuf[23:16] = dec_bits[7:0];
            n_obuf[31:24] = 8'h00;
            n_ocnt = 3'd1 + {2'b00, !fin_pad[1]} + {2'b00, !fin_pad[0]};
        end
        n_cnt = grp_n[1:0];
    end

    // group registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= b64sc_pkg::MODE_ENCODE;
            r_bits <= 24'h0;
            r_cnt  <= 2'd0;
            r_pad  <= 2'd0;
            r_err  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
            r_bits <= 24'h0;
            r_cnt  <= 2'd0;
            r_pad  <= 2'd0;
            r_err  <= 1'b0;
        end else if (in_acc) begin
            if (n_done) begin
                r_bits <= 24'h0;
                r_cnt  <= 2'd0;
                r_pad  <= 2'd0;
                r_err  <= 1'b0;
            end else begin
                r_bits <= n_bits;
                r_cnt  <= n_cnt;
                r_pad  <= n_pad;
                r_err  <= n_err;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 3'd0;
        end else if (in_acc && n_done) begin
            r_ocnt <= n_ocnt;
        end else if (out_acc) begin
            r_ocnt <= r_ocnt - 3'd1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && n_done) begin
            r_obuf <= n_obuf;
            r_oerr <= (r_mode == b64sc_pkg::MODE_DECODE) ? n_err : 1'b0;
        end else if (out_acc) begin
            r_obuf <= {8'h00, r_obuf[31:8]};
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // one result word as seen on m_axis
    typedef struct packed {
        logic [7:0] char_byte;
        logic       run_end;
        logic       bad_symbol;
    } t_out_word;

    // predicts the codec output and holds the words still to come
    class codec_scoreboard;
        logic        mode;
        logic [23:0] group_bits;
        int          group_count;
        logic [1:0]  pad_marks;
        logic        group_error;
        t_out_word   pending_out[$];
        int          errors;
        string       alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            mode = b64sc_pkg::MODE_ENCODE;
            errors = 0;
            clear_group();
        endfunction

        function void clear_group();
            group_bits = '0;
            group_count = 0;
            pad_marks = '0;
            group_error = 1'b0;
        endfunction

        // a mode write also drops any partial group
        function void set_mode(logic m);
            mode = m;
            clear_group();
        endfunction

        function logic [7:0] sym_to_char(logic [5:0] v);
            return alphabet[int'(v)];
        endfunction

        // alphabet position of a character, -1 when outside the alphabet
        function int char_to_sym(logic [7:0] c);
            for (int i = 0; i < 64; i++) begin
                if (alphabet[i] == c) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void emit(logic [7:0] b, logic err);
            t_out_word w;
            w.char_byte = b;
            w.run_end = 1'b0;
            w.bad_symbol = err;
            pending_out.push_back(w);
        endfunction

        // accepted input word: update the group, queue any words it completes
        function void note_word(logic [7:0] b, logic last);
            int n;
            int s;
            int v;
            if (mode == b64sc_pkg::MODE_ENCODE) begin
                group_bits = group_bits | (24'(b) << (16 - 8 * group_count));
                n = group_count + 1;
                if (n < 3 && !last) begin
                    group_count = n;
                    return;
                end
                emit(sym_to_char(group_bits[23:18]), 1'b0);
                emit(sym_to_char(group_bits[17:12]), 1'b0);
                emit(n >= 2 ? sym_to_char(group_bits[11:6]) : b64sc_pkg::PAD_CHAR, 1'b0);
                emit(n >= 3 ? sym_to_char(group_bits[5:0]) : b64sc_pkg::PAD_CHAR, 1'b0);
            end else begin
                v = 0;
                if (b == b64sc_pkg::PAD_CHAR) begin
                    if (group_count == 2) pad_marks[1] = 1'b1;
                    if (group_count == 3) pad_marks[0] = 1'b1;
                end else begin
                    s = char_to_sym(b);
                    if (s < 0) group_error = 1'b1;
                    else v = s;
                end
                group_bits = group_bits | (24'(v) << (18 - 6 * group_count));
                n = group_count + 1;
                if (n < 4 && !last) begin
                    group_count = n;
                    return;
                end
                // positions never received count as pad
                if (n < 3) pad_marks[1] = 1'b1;
                if (n < 4) pad_marks[0] = 1'b1;
                emit(group_bits[23:16], group_error);
                if (!pad_marks[1]) emit(group_bits[15:8], group_error);
                if (!pad_marks[0]) emit(group_bits[7:0], group_error);
            end
            pending_out[pending_out.size() - 1].run_end = 1'b1;
            clear_group();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [7:0] d, logic l, logic u);
            t_out_word w;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", d));
                return;
            end
            w = pending_out.pop_front();
            if (d !== w.char_byte)
                report_mismatch($sformatf("byte %h, expected %h", d, w.char_byte));
            if (l !== w.run_end)
                report_mismatch($sformatf("tlast %b, expected %b", l, w.run_end));
            if (u !== w.bad_symbol)
                report_mismatch($sformatf("bad_symbol %b, expected %b", u, w.bad_symbol));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;   // [0] bad_symbol

    codec_scoreboard sb;
    bit              gapless;
    bit              hold_off_req;
    int              words_sent;

    base64_stream_codec_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_sym();
        return sb.sym_to_char(6'($urandom_range(0, 63)));
    endfunction

    // offer one word on s_axis and wait for it to be taken
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(b, last);
        words_sent++;
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // let every expected word out, then add slack before returning
    task automatic wait_drain();
        int w;
        for (w = 0; w < 20000 && sb.pending_out.size() != 0; w++)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_byte_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // well-formed text groups with some noise mixed in
    task automatic send_b64_message();
        logic [7:0] text[$];
        int         tail;
        int         r;
        repeat ($urandom_range(0, 3) * 4) text.push_back(rand_sym());
        tail = $urandom_range(0, 5);
        case (tail)
            0: begin
                repeat (4) text.push_back(rand_sym());
            end
            1: begin
                repeat (2) text.push_back(rand_sym());
                repeat (2) text.push_back(b64sc_pkg::PAD_CHAR);
            end
            2: begin
                repeat (3) text.push_back(rand_sym());
                text.push_back(b64sc_pkg::PAD_CHAR);
            end
            default: begin
                repeat ($urandom_range(1, 3)) text.push_back(rand_sym());
            end
        endcase
        // stray bytes and misplaced pad chars
        foreach (text[i]) begin
            r = $urandom_range(0, 99);
            if (r < 8) text[i] = 8'($urandom_range(0, 255));
            else if (r < 12) text[i] = b64sc_pkg::PAD_CHAR;
        end
        foreach (text[i])
            send_word(text[i], i == text.size() - 1);
    endtask

    // m_axis side: check accepted words, stall at random
    initial begin
        int stall_left;
        int steady_left;
        stall_left = 0;
        steady_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = 200;
                steady_left = 0;
            end else if (stall_left == 0 && steady_left == 0) begin
                if ($urandom_range(0, 63) == 0) steady_left = 60;
                else stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (steady_left > 0) steady_left--;
            end
        end
    end

    // stimulus
    initial begin
        int start;
        sb = new();
        gapless = 1'b0;
        hold_off_req = 1'b0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        s_axis_tlast <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: one, two and three byte groups, then a partial left hanging
        write_mode(b64sc_pkg::MODE_ENCODE);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h12, 1'b0);

        // decode: plain, pad in third and fourth, pad up front, short and bad groups
        write_mode(b64sc_pkg::MODE_DECODE);
        send_text("TWFu", 1'b0);
        send_text("QU==", 1'b0);
        send_text("==+/", 1'b0);
        send_text("z!", 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(b64sc_pkg::CHAR_9, 1'b1);
        send_word(b64sc_pkg::CHAR_UP_A, 1'b0);

        // random phases, alternating modes
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase % 2 ? b64sc_pkg::MODE_DECODE : b64sc_pkg::MODE_ENCODE);
            start = words_sent;
            // long receiver hold-off while the sender keeps pushing
            if (phase == 2) hold_off_req = 1'b1;
            while (words_sent - start < 104) begin
                gapless = (words_sent - start < 25) || (phase == 2 && words_sent - start < 45);
                if (phase % 2) send_b64_message();
                else send_byte_message();
            end
            gapless = 1'b0;
            // sometimes leave a partial group for the mode write to drop
            if ($urandom_range(0, 1))
                send_word(8'($urandom_range(0, 255)), 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        wait_drain();
        if (sb.pending_out.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_out.size()));
        if (sb.errors == 0)
            $display("PASS base64_stream_codec_top");
        else
            $display("FAIL base64_stream_codec_top");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAIL base64_stream_codec_top");
        $finish;
    end

endmodule
